>>> hw/rtl/vms_pkg.sv
`default_nettype none

package vms_pkg;

    // configuration register indexes
    localparam logic [1:0] CFG_LAMBDA = 2'd0;
    localparam logic [1:0] CFG_MU     = 2'd1;
    localparam logic [1:0] CFG_CYL    = 2'd2;

    // per-transaction status carried down the pipe
    typedef struct packed {
        logic hoop;   // hoop term applies
        logic neg;    // hoop quotient is negative
        logic zr;     // cylindrical mode met a zero radius
        logic sat;    // result clips
    } vms_flags_t;

endpackage

`default_nettype wire

>>> hw/rtl/vms_front.sv
`default_nettype none

module vms_front #(
    parameter int W = 32,
    parameter int F = 16
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  en,
    input  wire logic                  in_vld,
    input  wire logic signed [W-1:0]   du_dx,
    input  wire logic signed [W-1:0]   du_dy,
    input  wire logic signed [W-1:0]   dv_dx,
    input  wire logic signed [W-1:0]   dv_dy,
    input  wire logic signed [W-1:0]   radial_disp,
    input  wire logic signed [W-1:0]   radius,
    input  wire logic signed [W-1:0]   mu,
    input  wire logic                  cyl,
    output logic                       out_vld,
    output logic signed [2*W+1:0]      dxy,
    output logic signed [2*W:0]        dxz,
    output logic signed [2*W:0]        dyz,
    output logic signed [2*W:0]        txy,
    output logic [2*W+F:0]             num,
    output logic [W-1:0]               den,
    output vms_pkg::vms_flags_t        flags
);

    localparam int TW = 2*W + 1;
    localparam int XW = 2*W + 2;
    localparam int NW = TW + F;

    logic signed [W:0]    two_mu;
    logic signed [W:0]    diff;
    logic signed [W:0]    shr;
    logic signed [XW-1:0] dxy_next;
    logic signed [TW-1:0] dxz_next, dyz_next, txy_next, hp_next;
    logic                 r_zero;

    // stage 1: products
    logic                 v1_reg;
    logic signed [XW-1:0] dxy1_reg;
    logic signed [TW-1:0] dxz1_reg, dyz1_reg, txy1_reg, hp_reg;
    logic signed [W-1:0]  r_reg;
    logic                 hoop_reg, zr_reg;

    // stage 2: magnitudes for the divider
    logic [TW-1:0]        hp_mag;
    logic [W-1:0]         r_mag;
    logic                 v2_reg;
    logic signed [XW-1:0] dxy2_reg;
    logic signed [TW-1:0] dxz2_reg, dyz2_reg, txy2_reg;
    logic [NW-1:0]        num_reg;
    logic [W-1:0]         den_reg;
    vms_pkg::vms_flags_t  flags_reg;

    always_comb
    begin
        two_mu   = {mu, 1'b0};
        diff     = {du_dx[W-1], du_dx} - {dv_dy[W-1], dv_dy};
        shr      = {du_dy[W-1], du_dy} + {dv_dx[W-1], dv_dx};
        dxy_next = two_mu * diff;
        dxz_next = two_mu * du_dx;
        dyz_next = two_mu * dv_dy;
        txy_next = mu * shr;
        hp_next  = two_mu * radial_disp;
        r_zero   = (radius == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dxy1_reg <= dxy_next;
            dxz1_reg <= dxz_next;
            dyz1_reg <= dyz_next;
            txy1_reg <= txy_next;
            hp_reg   <= hp_next;
            r_reg    <= radius;
            hoop_reg <= cyl && !r_zero;
            zr_reg   <= cyl && r_zero;
        end
    end

    always_comb
    begin
        hp_mag = hp_reg[TW-1] ? TW'(-hp_reg) : TW'(hp_reg);
        r_mag  = r_reg[W-1] ? W'(-r_reg) : W'(r_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dxy2_reg       <= dxy1_reg;
            dxz2_reg       <= dxz1_reg;
            dyz2_reg       <= dyz1_reg;
            txy2_reg       <= txy1_reg;
            num_reg        <= {hp_mag, {F{1'b0}}};
            den_reg        <= r_mag;
            flags_reg.hoop <= hoop_reg;
            flags_reg.neg  <= hp_reg[TW-1] ^ r_reg[W-1];
            flags_reg.zr   <= zr_reg;
            flags_reg.sat  <= 1'b0;
        end
    end

    assign out_vld = v2_reg;
    assign dxy     = dxy2_reg;
    assign dxz     = dxz2_reg;
    assign dyz     = dyz2_reg;
    assign txy     = txy2_reg;
    assign num     = num_reg;
    assign den     = den_reg;
    assign flags   = flags_reg;

endmodule

`default_nettype wire

>>> hw/rtl/vms_div.sv
`default_nettype none

// Restoring divider, one quotient bit per stage, sideband rides along.
module vms_div #(
    parameter int NW = 81,
    parameter int DW = 32,
    parameter int SW = 8
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          en,
    input  wire logic          in_vld,
    input  wire logic [NW-1:0] num,
    input  wire logic [DW-1:0] den,
    input  wire logic [SW-1:0] sb_in,
    output logic               out_vld,
    output logic [NW-1:0]      quo,
    output logic [SW-1:0]      sb_out
);

    logic [NW-1:0] nq_reg  [NW];
    logic [DW-1:0] rem_reg [NW];
    logic [DW-1:0] den_reg [NW];
    logic [SW-1:0] sb_reg  [NW];
    logic [NW-1:0] vld_reg;

    logic [NW-1:0] nq_in  [NW];
    logic [DW-1:0] rem_in [NW];
    logic [DW-1:0] den_in [NW];
    logic [SW-1:0] sb_st  [NW];
    logic [NW-1:0] vld_in;

    for (genvar k = 0; k < NW; k++)
    begin : g_stage
        logic [DW:0]   trial;
        logic          ge;
        logic [DW-1:0] rem_next;

        if (k == 0)
        begin : g_first
            assign nq_in[k]  = num;
            assign rem_in[k] = '0;
            assign den_in[k] = den;
            assign sb_st[k]  = sb_in;
            assign vld_in[k] = in_vld;
        end
        else
        begin : g_rest
            assign nq_in[k]  = nq_reg[k-1];
            assign rem_in[k] = rem_reg[k-1];
            assign den_in[k] = den_reg[k-1];
            assign sb_st[k]  = sb_reg[k-1];
            assign vld_in[k] = vld_reg[k-1];
        end

        always_comb
        begin
            trial    = {rem_in[k], nq_in[k][NW-1]};
            ge       = (trial >= {1'b0, den_in[k]});
            rem_next = ge ? DW'(trial - {1'b0, den_in[k]}) : trial[DW-1:0];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[k] <= vld_in[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                nq_reg[k]  <= {nq_in[k][NW-2:0], ge};
                rem_reg[k] <= rem_next;
                den_reg[k] <= den_in[k];
                sb_reg[k]  <= sb_st[k];
            end
        end
    end

    assign out_vld = vld_reg[NW-1];
    assign quo     = nq_reg[NW-1];
    assign sb_out  = sb_reg[NW-1];

endmodule

`default_nettype wire

>>> hw/rtl/vms_sq.sv
`default_nettype none

// Hoop correction, magnitudes, split squares and the scaled sum.
module vms_sq #(
    parameter int W = 32,
    parameter int F = 16
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  en,
    input  wire logic                  in_vld,
    input  wire logic [2*W+F:0]        quo,
    input  wire logic signed [2*W+1:0] dxy,
    input  wire logic signed [2*W:0]   dxz,
    input  wire logic signed [2*W:0]   dyz,
    input  wire logic signed [2*W:0]   txy,
    input  wire vms_pkg::vms_flags_t   flags_in,
    output logic                       out_vld,
    output logic [2*W-1:0]             rad,
    output vms_pkg::vms_flags_t        flags_out
);

    localparam int NW   = 2*W + F + 1;
    localparam int DW   = NW + 2;
    localparam int M    = W + F + 1;
    localparam int L    = (M + 1) / 2;
    localparam int H    = M - L;
    localparam int SQW  = 2*M;
    localparam int SUMW = 2*M + 4;
    localparam int RW   = 2*W;
    localparam int NS   = 5;

    logic [NS-1:0]       vld_reg;
    vms_pkg::vms_flags_t fl_reg [NS];

    // C: differences with hoop term
    logic signed [DW-1:0] qv, qs;
    logic signed [DW-1:0] d_reg [4];

    always_comb
    begin
        qv = {2'b00, quo};
        qs = flags_in.hoop ? (flags_in.neg ? -qv : qv) : '0;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_reg[0]  <= DW'(dxy);
            d_reg[1]  <= DW'(dxz) - qs;
            d_reg[2]  <= DW'(dyz) - qs;
            d_reg[3]  <= DW'(txy);
            fl_reg[0] <= flags_in;
        end
    end

    // D: magnitudes, anything at or above 2^M saturates
    logic [DW-1:0] a_abs [4];
    logic [M-1:0]  mag_reg [4];
    logic          ovf;

    always_comb
    begin
        ovf = 1'b0;
        for (int i = 0; i < 4; i++)
        begin
            a_abs[i] = d_reg[i][DW-1] ? DW'(-d_reg[i]) : DW'(d_reg[i]);
            ovf      = ovf | (|a_abs[i][DW-1:M]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 4; i++)
            begin
                mag_reg[i] <= a_abs[i][M-1:0];
            end
            fl_reg[1] <= '{hoop: fl_reg[0].hoop, neg: fl_reg[0].neg,
                           zr: fl_reg[0].zr, sat: ovf};
        end
    end

    // E: partial products of each square
    logic [2*H-1:0] hh_reg [4];
    logic [H+L-1:0] hl_reg [4];
    logic [2*L-1:0] ll_reg [4];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 4; i++)
            begin
                hh_reg[i] <= mag_reg[i][M-1:L] * mag_reg[i][M-1:L];
                hl_reg[i] <= mag_reg[i][M-1:L] * mag_reg[i][L-1:0];
                ll_reg[i] <= mag_reg[i][L-1:0] * mag_reg[i][L-1:0];
            end
            fl_reg[2] <= fl_reg[1];
        end
    end

    // F: assemble squares
    logic [SQW-1:0] sq_reg [4];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 4; i++)
            begin
                sq_reg[i] <= (SQW'(hh_reg[i]) << (2*L)) + (SQW'(hl_reg[i]) << (L+1))
                           + SQW'(ll_reg[i]);
            end
            fl_reg[3] <= fl_reg[2];
        end
    end

    // G: sum with 6*txy^2, halve and drop the extra fraction bits
    logic [SUMW-1:0] sum, scaled;
    logic [RW-1:0]   rad_reg;

    always_comb
    begin
        sum = SUMW'(sq_reg[0]) + SUMW'(sq_reg[1]) + SUMW'(sq_reg[2])
            + (SUMW'(sq_reg[3]) << 2) + (SUMW'(sq_reg[3]) << 1);
        scaled = sum >> (2*F + 1);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rad_reg   <= scaled[RW-1:0];
            fl_reg[4] <= '{hoop: fl_reg[3].hoop, neg: fl_reg[3].neg, zr: fl_reg[3].zr,
                           sat: fl_reg[3].sat | (|scaled[SUMW-1:RW])};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[NS-2:0], in_vld};
        end
    end

    assign out_vld   = vld_reg[NS-1];
    assign rad       = rad_reg;
    assign flags_out = fl_reg[NS-1];

endmodule

`default_nettype wire

>>> hw/rtl/vms_sqrt.sv
`default_nettype none

// Digit-by-digit integer square root, one root bit per stage.
module vms_sqrt #(
    parameter int W = 32
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                en,
    input  wire logic                in_vld,
    input  wire logic [2*W-1:0]      rad,
    input  wire vms_pkg::vms_flags_t flags_in,
    output logic                     out_vld,
    output logic [W-1:0]             root,
    output vms_pkg::vms_flags_t      flags_out
);

    localparam int RW = 2*W;

    logic [W+1:0]        rem_reg  [W];
    logic [W-1:0]        root_reg [W];
    logic [RW-1:0]       rad_reg  [W];
    vms_pkg::vms_flags_t fl_reg   [W];
    logic [W-1:0]        vld_reg;

    logic [W+1:0]        rem_in  [W];
    logic [W-1:0]        root_in [W];
    logic [RW-1:0]       rad_in  [W];
    vms_pkg::vms_flags_t fl_in   [W];
    logic [W-1:0]        vld_in;

    for (genvar k = 0; k < W; k++)
    begin : g_stage
        logic [W+3:0] tmp, trial;
        logic         ge;

        if (k == 0)
        begin : g_first
            assign rem_in[k]  = '0;
            assign root_in[k] = '0;
            assign rad_in[k]  = rad;
            assign fl_in[k]   = flags_in;
            assign vld_in[k]  = in_vld;
        end
        else
        begin : g_rest
            assign rem_in[k]  = rem_reg[k-1];
            assign root_in[k] = root_reg[k-1];
            assign rad_in[k]  = rad_reg[k-1];
            assign fl_in[k]   = fl_reg[k-1];
            assign vld_in[k]  = vld_reg[k-1];
        end

        always_comb
        begin
            tmp   = {rem_in[k], rad_in[k][RW-1:RW-2]};
            trial = {2'b00, root_in[k], 2'b01};
            ge    = (tmp >= trial);
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[k] <= vld_in[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k]  <= ge ? (W+2)'(tmp - trial) : tmp[W+1:0];
                root_reg[k] <= {root_in[k][W-2:0], ge};
                rad_reg[k]  <= rad_in[k] << 2;
                fl_reg[k]   <= fl_in[k];
            end
        end
    end

    assign out_vld   = vld_reg[W-1];
    assign root      = root_reg[W-1];
    assign flags_out = fl_reg[W-1];

endmodule

`default_nettype wire

>>> hw/rtl/von_mises_stress_unit.sv
// von_mises_stress_unit: von Mises equivalent stress of one quadrature point
// per transaction, plane or axisymmetric, all values two's complement Q16.16.
// Input channel: in_valid / in_stall with du_dx, du_dy, dv_dx, dv_dy,
// radial_disp and radius. Output channel: out_valid / out_stall with
// equiv_stress (unsigned), saturated and zero_radius.
// Configuration: cfg_we writes cfg_data to register cfg_index (0 lambda,
// 1 shear modulus, 2 cylindrical mode bit 0); write only while idle.
// Lambda cancels out of every stress difference, so it is not stored.
// Throughput: one transaction per cycle unless the output stalls. The
// pipe holds the bit-per-stage hoop divider (2*W+F+1 stages) and the
// bit-per-stage square root (W stages).
// Reset clears all valid bits and the configuration; no clearing pass.
// A stall on the output while a result waits there freezes the whole pipe
// and raises in_stall in the same cycle; nothing is dropped or repeated.
`default_nettype none

module von_mises_stress_unit #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cfg_we,
    input  wire logic [1:0]                   cfg_index,
    input  wire logic [DATA_WIDTH-1:0]        cfg_data,
    input  wire logic                         in_valid,
    output logic                              in_stall,
    input  wire logic signed [DATA_WIDTH-1:0] du_dx,
    input  wire logic signed [DATA_WIDTH-1:0] du_dy,
    input  wire logic signed [DATA_WIDTH-1:0] dv_dx,
    input  wire logic signed [DATA_WIDTH-1:0] dv_dy,
    input  wire logic signed [DATA_WIDTH-1:0] radial_disp,
    input  wire logic signed [DATA_WIDTH-1:0] radius,
    output logic                              out_valid,
    input  wire logic                         out_stall,
    output logic [DATA_WIDTH-1:0]             equiv_stress,
    output logic                              saturated,
    output logic                              zero_radius
);

    localparam int W   = DATA_WIDTH;
    localparam int F   = FRAC_BITS;
    localparam int TW  = 2*W + 1;
    localparam int XW  = 2*W + 2;
    localparam int NW  = TW + F;
    localparam int FLW = $bits(vms_pkg::vms_flags_t);
    localparam int SBW = FLW + XW + 3*TW;

    // configuration
    logic signed [W-1:0] mu_reg;
    logic                cyl_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mu_reg  <= '0;
            cyl_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                vms_pkg::CFG_LAMBDA: ;  // cancels in the differences
                vms_pkg::CFG_MU:     mu_reg  <= cfg_data;
                vms_pkg::CFG_CYL:    cyl_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // whole pipe advances unless a finished result is held by the receiver
    logic en;
    logic out_valid_reg;

    assign en       = !(out_valid_reg && out_stall);
    assign in_stall = !en;

    // front: products and divider operands
    logic                 f_vld;
    logic signed [XW-1:0] f_dxy;
    logic signed [TW-1:0] f_dxz, f_dyz, f_txy;
    logic [NW-1:0]        f_num;
    logic [W-1:0]         f_den;
    vms_pkg::vms_flags_t  f_flags;

    vms_front #(.W(W), .F(F)) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (en),
        .in_vld      (in_valid),
        .du_dx       (du_dx),
        .du_dy       (du_dy),
        .dv_dx       (dv_dx),
        .dv_dy       (dv_dy),
        .radial_disp (radial_disp),
        .radius      (radius),
        .mu          (mu_reg),
        .cyl         (cyl_reg),
        .out_vld     (f_vld),
        .dxy         (f_dxy),
        .dxz         (f_dxz),
        .dyz         (f_dyz),
        .txy         (f_txy),
        .num         (f_num),
        .den         (f_den),
        .flags       (f_flags)
    );

    // hoop divider; stress terms ride as sideband
    logic                 d_vld;
    logic [NW-1:0]        d_quo;
    logic [SBW-1:0]       d_sb;
    logic signed [XW-1:0] d_dxy;
    logic signed [TW-1:0] d_dxz, d_dyz, d_txy;
    vms_pkg::vms_flags_t  d_flags;

    vms_div #(.NW(NW), .DW(W), .SW(SBW)) u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .in_vld  (f_vld),
        .num     (f_num),
        .den     (f_den),
        .sb_in   ({f_flags, f_dxy, f_dxz, f_dyz, f_txy}),
        .out_vld (d_vld),
        .quo     (d_quo),
        .sb_out  (d_sb)
    );

    assign {d_flags, d_dxy, d_dxz, d_dyz, d_txy} = d_sb;

    // squares and scaled sum
    logic                s_vld;
    logic [2*W-1:0]      s_rad;
    vms_pkg::vms_flags_t s_flags;

    vms_sq #(.W(W), .F(F)) u_sq (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_vld    (d_vld),
        .quo       (d_quo),
        .dxy       (d_dxy),
        .dxz       (d_dxz),
        .dyz       (d_dyz),
        .txy       (d_txy),
        .flags_in  (d_flags),
        .out_vld   (s_vld),
        .rad       (s_rad),
        .flags_out (s_flags)
    );

    // square root
    logic                r_vld;
    logic [W-1:0]        r_root;
    vms_pkg::vms_flags_t r_flags;

    vms_sqrt #(.W(W)) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_vld    (s_vld),
        .rad       (s_rad),
        .flags_in  (s_flags),
        .out_vld   (r_vld),
        .root      (r_root),
        .flags_out (r_flags)
    );

    // output register
    logic [W-1:0] equiv_reg;
    logic         sat_reg, zr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= r_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            equiv_reg <= r_flags.sat ? '1 : r_root;
            sat_reg   <= r_flags.sat;
            zr_reg    <= r_flags.zr;
        end
    end

    assign out_valid    = out_valid_reg;
    assign equiv_stress = equiv_reg;
    assign saturated    = sat_reg;
    assign zero_radius  = zr_reg;

    // a clipped result is all ones
    a_sat_ones: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && saturated |-> equiv_stress == '1)
        else $error("saturated result not all ones");

    // zero radius can only come from cylindrical mode
    a_zr_cyl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && zero_radius |-> cyl_reg)
        else $error("zero_radius flagged in plane mode");

    // with no shear modulus every stress difference vanishes
    a_mu_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && mu_reg == '0 |-> equiv_stress == '0 && !saturated)
        else $error("nonzero stress with zero shear modulus");

endmodule

`default_nettype wire
